// ===== design/ucd_pkg.sv =====
// shared types and constants for the utf-8 codepoint decoder
// no dependencies

package ucd_pkg;

   localparam int unsigned CpWidth    = 21;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned PendWidth  = 2;
   localparam int unsigned FifoDepth  = 4;
   localparam int unsigned FifoAw     = $clog2(FifoDepth);
   localparam int unsigned FifoCw     = $clog2(FifoDepth + 1);

   localparam logic [CpWidth-1:0] ReplValue = CpWidth'(8'h7F);

   typedef enum logic {
      ACT_DATA = 1'b0,
      ACT_END  = 1'b1
   } action_type;

   typedef struct packed {
      logic [CpWidth-1:0] out_value;
      logic               needs_mapping;
      logic               last_of_run;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } result_pair_type;

endpackage

// ===== design/ucd_decode.sv =====
// per-byte decode: holds the partial codepoint and pending count
// produces up to two result beats per item; uses ucd_pkg

module ucd_decode (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              item_valid,
   input  logic                              item_action,
   input  logic [ucd_pkg::ByteWidth-1:0]     item_byte,
   output ucd_pkg::result_pair_type          results
);

   logic [ucd_pkg::CpWidth-1:0]   partial_ff, partial_in;
   logic [ucd_pkg::PendWidth-1:0] pending_ff, pending_in;
   logic                          first_repl;
   logic                          main_valid;
   ucd_pkg::result_type           main_res;
   ucd_pkg::result_type           repl_res;
   logic [ucd_pkg::CpWidth-1:0]   shifted;

   always_comb begin
      repl_res.out_value     = ucd_pkg::ReplValue;
      repl_res.needs_mapping = 1'b0;
      repl_res.last_of_run   = 1'b0;
      shifted = {partial_ff[ucd_pkg::CpWidth-7:0], item_byte[5:0]};

      partial_in = partial_ff;
      pending_in = pending_ff;
      first_repl = 1'b0;
      main_valid = 1'b0;
      main_res   = repl_res;

      if (ucd_pkg::action_type'(item_action) == ucd_pkg::ACT_END) begin
         first_repl = (pending_ff != '0);
         partial_in = '0;
         pending_in = '0;
      end else if (item_byte[7] == 1'b0) begin
         first_repl = (pending_ff != '0);
         main_valid = 1'b1;
         main_res.out_value = ucd_pkg::CpWidth'(item_byte);
         pending_in = '0;
      end else if (item_byte[7:6] == 2'b10) begin
         if (pending_ff == '0) begin
            main_valid = 1'b1;
         end else begin
            partial_in = shifted;
            pending_in = pending_ff - 1'b1;
            if (pending_ff == 2'd1) begin
               main_valid = 1'b1;
               main_res.out_value     = shifted;
               main_res.needs_mapping = 1'b1;
            end
         end
      end else begin
         first_repl = (pending_ff != '0);
         priority if (item_byte[7:5] == 3'b110) begin
            partial_in = ucd_pkg::CpWidth'(item_byte[4:0]);
            pending_in = 2'd1;
         end else if (item_byte[7:4] == 4'b1110) begin
            partial_in = ucd_pkg::CpWidth'(item_byte[3:0]);
            pending_in = 2'd2;
         end else if (item_byte[7:3] == 5'b11110) begin
            partial_in = ucd_pkg::CpWidth'(item_byte[2:0]);
            pending_in = 2'd3;
         end else begin
            main_valid = 1'b1;
            pending_in = '0;
         end
      end

      results.first  = repl_res;
      results.second = main_res;
      results.count  = 2'd0;
      if (first_repl && main_valid) begin
         results.count = 2'd2;
         results.second.last_of_run = 1'b1;
      end else if (first_repl) begin
         results.count = 2'd1;
         results.first.last_of_run = 1'b1;
      end else if (main_valid) begin
         results.count = 2'd1;
         results.first = main_res;
         results.first.last_of_run = 1'b1;
      end
      if (!item_valid) begin
         results.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         pending_ff <= '0;
      end else if (item_valid) begin
         partial_ff <= partial_in;
         pending_ff <= pending_in;
      end
   end

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (item_valid && item_action) |=> (pending_ff == '0 && partial_ff == '0))
      else $error("end of string did not clear decode state");

endmodule

// ===== design/ucd_result_fifo.sv =====
// result queue: takes up to two beats per cycle, gives one per cycle while out_stall is low
// uses ucd_pkg

module ucd_result_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  ucd_pkg::result_pair_type push,
   output logic                     room,
   output logic                     out_valid,
   input  logic                     out_stall,
   output ucd_pkg::result_type      out_beat
);

   ucd_pkg::result_type               mem_ff [ucd_pkg::FifoDepth];
   logic [ucd_pkg::FifoAw-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [ucd_pkg::FifoAw-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [ucd_pkg::FifoCw-1:0]        count_ff, count_in;
   logic [ucd_pkg::FifoAw-1:0]        wr_ptr_next;
   logic                              pop;

   assign out_valid   = (count_ff != '0);
   assign out_beat    = mem_ff[rd_ptr_ff];
   assign room        = (count_ff <= ucd_pkg::FifoCw'(ucd_pkg::FifoDepth - 2));
   assign pop         = out_valid && !out_stall;
   assign wr_ptr_next = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + ucd_pkg::FifoAw'(push.count);
      rd_ptr_in = rd_ptr_ff + ucd_pkg::FifoAw'(pop);
      count_in  = count_ff + ucd_pkg::FifoCw'(push.count) - ucd_pkg::FifoCw'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push.second;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ucd_pkg::FifoCw'(ucd_pkg::FifoDepth))
      else $error("result queue overflow");

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> room)
      else $error("beats pushed without room");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (pop && push.count == 2'd0) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count wrong after pop");

endmodule

// ===== design/utf8_codepoint_decoder.sv =====
// utf-8 codepoint decoder top level
// depends on ucd_pkg, ucd_decode and ucd_result_fifo
//
// usage:
//  req channel: one beat per byte (req_action = 0) or an end-of-string
//  beat (req_action = 1). a beat is taken when req_valid is high and
//  req_stall is low.
//  rsp channel: zero, one or two beats per request beat; rsp_last_of_run
//  marks the final beat caused by a request. rsp_needs_mapping marks a
//  completed multi-byte codepoint.
//  path: a taken request beat goes into the input register, then is decoded
//  into the result queue once it has room, from which its first result beat is offered.
//  throughput: one request beat per cycle while each gives at most one
//  result and rsp_stall is low; a request giving two results is limited by
//  the single read port of the four-entry result queue.
//  stall: when rsp_stall holds, results collect in the queue; once fewer
//  than two entries are free the input register holds and req_stall rises.
//  reset: synchronous; clears the partial codepoint, pending count, the
//  input register's valid flag and the result queue's pointers and count.

module utf8_codepoint_decoder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_action,
   input  logic [ucd_pkg::ByteWidth-1:0]    req_in_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ucd_pkg::CpWidth-1:0]      rsp_out_value,
   output logic                             rsp_needs_mapping,
   output logic                             rsp_last_of_run
);

   logic                          in_valid_ff, in_valid_in;
   logic                          in_action_ff;
   logic [ucd_pkg::ByteWidth-1:0] in_byte_ff;
   logic                          room;
   logic                          advance;
   logic                          accept;
   ucd_pkg::result_pair_type      results;
   ucd_pkg::result_type           out_beat;

   assign advance   = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_action_ff <= req_action;
         in_byte_ff   <= req_in_byte;
      end
   end

   ucd_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (advance),
      .item_action (in_action_ff),
      .item_byte   (in_byte_ff),
      .results     (results)
   );

   ucd_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (results),
      .room      (room),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_beat  (out_beat)
   );

   assign rsp_out_value     = out_beat.out_value;
   assign rsp_needs_mapping = out_beat.needs_mapping;
   assign rsp_last_of_run   = out_beat.last_of_run;

endmodule

// ===== tb/utf8_codepoint_decoder_check.sv =====
`timescale 1ns / 100ps
// checker for the utf-8 codepoint decoder: watches the request and result channels,
// decodes each accepted request beat into the result beats it should cause and
// compares every result beat in order; depends on ucd_pkg

module utf8_codepoint_decoder_check (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          req_action,
   input  logic [ucd_pkg::ByteWidth-1:0] req_in_byte,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [ucd_pkg::CpWidth-1:0]   rsp_out_value,
   input  logic                          rsp_needs_mapping,
   input  logic                          rsp_last_of_run,
   output int                            mismatch_count,
   output int                            results_awaited,
   output int                            result_beats,
   output int                            codepoints_seen
);

   ucd_pkg::result_type           expected_chars[$];
   logic [ucd_pkg::CpWidth-1:0]   partial_cp = '0;
   logic [ucd_pkg::PendWidth-1:0] conts_left = '0;
   int                            errors     = 0;
   int                            seen       = 0;
   int                            decoded    = 0;

   function automatic ucd_pkg::result_type make_result(logic [ucd_pkg::CpWidth-1:0] value,
                                                       logic mapped_flag);
      ucd_pkg::result_type r;
      r.out_value     = value;
      r.needs_mapping = mapped_flag;
      r.last_of_run   = 1'b0;
      return r;
   endfunction

   task automatic decode_beat(input ucd_pkg::action_type act,
                              input logic [ucd_pkg::ByteWidth-1:0] b);
      ucd_pkg::result_type run[$];
      ucd_pkg::result_type tail;
      run = {};
      if (act == ucd_pkg::ACT_END) begin
         if (conts_left != 0) run.push_back(make_result(ucd_pkg::ReplValue, 1'b0));
         partial_cp = '0;
         conts_left = '0;
      end else if (b[7] == 1'b0) begin
         // ascii breaks off any open sequence
         if (conts_left != 0) begin
            run.push_back(make_result(ucd_pkg::ReplValue, 1'b0));
            conts_left = '0;
         end
         run.push_back(make_result(ucd_pkg::CpWidth'(b), 1'b0));
      end else if (b[7:6] == 2'b10) begin
         if (conts_left == 0) begin
            run.push_back(make_result(ucd_pkg::ReplValue, 1'b0));
         end else begin
            partial_cp = {partial_cp[ucd_pkg::CpWidth-7:0], b[5:0]};
            conts_left = conts_left - 1'b1;
            if (conts_left == 0) run.push_back(make_result(partial_cp, 1'b1));
         end
      end else begin
         if (conts_left != 0) run.push_back(make_result(ucd_pkg::ReplValue, 1'b0));
         if (b[7:5] == 3'b110) begin
            partial_cp = ucd_pkg::CpWidth'(b[4:0]);
            conts_left = 2'd1;
         end else if (b[7:4] == 4'b1110) begin
            partial_cp = ucd_pkg::CpWidth'(b[3:0]);
            conts_left = 2'd2;
         end else if (b[7:3] == 5'b11110) begin
            partial_cp = ucd_pkg::CpWidth'(b[2:0]);
            conts_left = 2'd3;
         end else begin
            // invalid lead keeps the partial codepoint
            run.push_back(make_result(ucd_pkg::ReplValue, 1'b0));
            conts_left = '0;
         end
      end
      if (run.size() > 0) begin
         tail = run.pop_back();
         tail.last_of_run = 1'b1;
         run.push_back(tail);
      end
      foreach (run[i]) expected_chars.push_back(run[i]);
   endtask

   always @(posedge clock) begin : watch
      ucd_pkg::result_type want;
      if (reset) begin
         expected_chars.delete();
         partial_cp = '0;
         conts_left = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen++;
            if (rsp_needs_mapping) decoded++;
            if (expected_chars.size() == 0) begin
               $error("unexpected result beat: out_value %h", rsp_out_value);
               errors++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_out_value !== want.out_value) begin
                  $error("out_value: expected %h, actual %h", want.out_value, rsp_out_value);
                  errors++;
               end
               if (rsp_needs_mapping !== want.needs_mapping) begin
                  $error("needs_mapping: expected %b, actual %b",
                         want.needs_mapping, rsp_needs_mapping);
                  errors++;
               end
               if (rsp_last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %b, actual %b",
                         want.last_of_run, rsp_last_of_run);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            decode_beat(ucd_pkg::action_type'(req_action), req_in_byte);
         end
      end
      mismatch_count  <= errors;
      results_awaited <= expected_chars.size();
      result_beats    <= seen;
      codepoints_seen <= decoded;
   end

endmodule

// ===== tb/utf8_codepoint_decoder_tb.sv =====
`timescale 1ns / 100ps
// testbench top for the utf-8 codepoint decoder: directed byte runs, then random
// well-formed, broken and noisy text with bursty requests and a stalling receiver;
// depends on ucd_pkg, utf8_codepoint_decoder and utf8_codepoint_decoder_check

module utf8_codepoint_decoder_tb;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_LONG
   } stall_pattern_type;

   localparam int RandomBeats = 600;

   localparam logic [8:0] DirectedBeats [25] = '{
      {ucd_pkg::ACT_DATA, 8'h00}, {ucd_pkg::ACT_DATA, 8'h7F},
      {ucd_pkg::ACT_DATA, 8'hC2}, {ucd_pkg::ACT_DATA, 8'hA9},
      {ucd_pkg::ACT_DATA, 8'hE2}, {ucd_pkg::ACT_DATA, 8'h82}, {ucd_pkg::ACT_DATA, 8'hAC},
      {ucd_pkg::ACT_DATA, 8'hF7}, {ucd_pkg::ACT_DATA, 8'hBF},
      {ucd_pkg::ACT_DATA, 8'hBF}, {ucd_pkg::ACT_DATA, 8'hBF},
      {ucd_pkg::ACT_DATA, 8'h80},
      {ucd_pkg::ACT_DATA, 8'hE2}, {ucd_pkg::ACT_DATA, 8'h41},
      {ucd_pkg::ACT_DATA, 8'hC3}, {ucd_pkg::ACT_DATA, 8'hE2},
      {ucd_pkg::ACT_DATA, 8'h82}, {ucd_pkg::ACT_DATA, 8'hAC},
      {ucd_pkg::ACT_DATA, 8'hF8},
      {ucd_pkg::ACT_DATA, 8'hF0}, {ucd_pkg::ACT_DATA, 8'hFF},
      {ucd_pkg::ACT_DATA, 8'hE2}, {ucd_pkg::ACT_DATA, 8'h82}, {ucd_pkg::ACT_END, 8'h00},
      {ucd_pkg::ACT_END, 8'hFF}
   };

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          req_valid   = 1'b0;
   logic                          req_stall;
   logic                          req_action  = ucd_pkg::ACT_DATA;
   logic [ucd_pkg::ByteWidth-1:0] req_in_byte = '0;
   logic                          rsp_valid;
   logic                          rsp_stall   = 1'b0;
   logic [ucd_pkg::CpWidth-1:0]   rsp_out_value;
   logic                          rsp_needs_mapping;
   logic                          rsp_last_of_run;

   int mismatch_count;
   int results_awaited;
   int result_beats;
   int codepoints_seen;
   int beats_sent  = 0;
   int ends_sent   = 0;
   int burst_left  = 0;
   int stall_cycle = 0;
   int stall_run   = 0;

   utf8_codepoint_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_value     (rsp_out_value),
      .rsp_needs_mapping (rsp_needs_mapping),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   utf8_codepoint_decoder_check check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_value     (rsp_out_value),
      .rsp_needs_mapping (rsp_needs_mapping),
      .rsp_last_of_run   (rsp_last_of_run),
      .mismatch_count    (mismatch_count),
      .results_awaited   (results_awaited),
      .result_beats      (result_beats),
      .codepoints_seen   (codepoints_seen)
   );

   always #5 clock = ~clock;

   // receiver stall pattern is chosen by bits 9:8 of a free-running cycle counter
   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 1;
      case (stall_pattern_type'(stall_cycle[9:8]))
         STALL_NONE: begin
            rsp_stall <= 1'b0;
         end
         STALL_LIGHT: begin
            rsp_stall <= ($urandom_range(0, 7) == 0);
         end
         STALL_HEAVY: begin
            rsp_stall <= 1'($urandom_range(0, 1));
         end
         default: begin
            if (stall_run != 0) begin
               stall_run <= stall_run - 1;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
               if ($urandom_range(0, 5) == 0) stall_run <= $urandom_range(1, 12);
            end
         end
      endcase
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   task automatic send_beat(input ucd_pkg::action_type act,
                            input logic [ucd_pkg::ByteWidth-1:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_valid   <= 1'b1;
      req_action  <= act;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      beats_sent++;
      if (act == ucd_pkg::ACT_END) ends_sent++;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_awaited != 0) @(posedge clock);
   endtask

   task automatic send_random_char();
      int                            kind;
      int                            len;
      int                            conts;
      logic [ucd_pkg::ByteWidth-1:0] lead;
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
         send_beat(ucd_pkg::ACT_DATA, 8'($urandom_range(0, 127)));
      end else if (kind < 83) begin
         len = $urandom_range(2, 4);
         case (len)
            2:       lead = {3'b110, 5'($urandom)};
            3:       lead = {4'b1110, 4'($urandom)};
            default: lead = {5'b11110, 3'($urandom)};
         endcase
         // short sequences get cut off by whatever comes next
         conts = (kind < 75) ? len - 1 : $urandom_range(0, len - 2);
         send_beat(ucd_pkg::ACT_DATA, lead);
         repeat (conts) send_beat(ucd_pkg::ACT_DATA, {2'b10, 6'($urandom)});
      end else if (kind < 93) begin
         send_beat(ucd_pkg::ACT_DATA, 8'($urandom));
      end else begin
         send_beat(ucd_pkg::ACT_END, 8'($urandom));
      end
   endtask

   initial begin : stimulus
      bit drained_midway;
      drained_midway = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (DirectedBeats[i])
         send_beat(ucd_pkg::action_type'(DirectedBeats[i][8]), DirectedBeats[i][7:0]);
      wait_for_drain();

      while (beats_sent < $size(DirectedBeats) + RandomBeats) begin
         send_random_char();
         if (!drained_midway && beats_sent > $size(DirectedBeats) + RandomBeats / 2) begin
            drained_midway = 1'b1;
            wait_for_drain();
         end
      end
      wait_for_drain();
      repeat (8) @(posedge clock);

      $display("request beats: %0d (%0d end of string), result beats: %0d",
               beats_sent, ends_sent, result_beats);
      $display("decoded codepoints: %0d, mismatches: %0d", codepoints_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/ucd_pkg.sv
design/ucd_decode.sv
design/ucd_result_fifo.sv
design/utf8_codepoint_decoder.sv
tb/utf8_codepoint_decoder_check.sv
tb/utf8_codepoint_decoder_tb.sv
